@@ src/wavp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types, constants and tag lookup for the WAV header parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

    localparam int          HDR_BYTES  = 44;
    localparam int          OFF_W      = 6;
    localparam int          DIVIDEND_W = 42;
    localparam int          DIVISOR_W  = 32;
    localparam int          DIV_CNT_W  = 6;
    localparam logic [9:0]  MS_SCALE   = 10'd1000;

    localparam logic [OFF_W-1:0] OFF_LAST_HDR = OFF_W'(HDR_BYTES - 1);
    localparam logic [OFF_W-1:0] OFF_DONE     = OFF_W'(HDR_BYTES);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_WAV   = 3'd1,
        ST_BAD_SIZE  = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_ZERO_CH   = 3'd4,
        ST_ZERO_RATE = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_RUN,
        S_CHECK,
        S_DIV_FRAMES,
        S_PREP,
        S_DIV_DUR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic emit_fail;
        logic start_frames;
        logic take_frames;
        logic start_dur;
        logic take_dur;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic hdr_done;
        logic pre_fail;
        logic rate_zero;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic       checked;
        logic [7:0] value;
    } t_tag;

    function automatic t_tag tag_at(input logic [OFF_W-1:0] off);
        t_tag t;
        t.checked = 1'b1;
        case (off)
            6'd0:    t.value = 8'h52;
            6'd1:    t.value = 8'h49;
            6'd2:    t.value = 8'h46;
            6'd3:    t.value = 8'h46;
            6'd8:    t.value = 8'h57;
            6'd9:    t.value = 8'h41;
            6'd10:   t.value = 8'h56;
            6'd11:   t.value = 8'h45;
            6'd12:   t.value = 8'h66;
            6'd13:   t.value = 8'h6d;
            6'd14:   t.value = 8'h74;
            6'd15:   t.value = 8'h20;
            default: begin
                t.checked = 1'b0;
                t.value   = 8'h00;
            end
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

@@ src/wavp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser channels
// Byte input channel and header result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wavp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wavp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] bits_per_sample;
    logic [31:0] data_length;
    logic [31:0] sample_frames;
    logic [41:0] duration_ms;

    modport source (output valid, output status, output channel_count, output rate_hz,
                    output bits_per_sample, output data_length, output sample_frames,
                    output duration_ms, input ready);
    modport sink   (input valid, input status, input channel_count, input rate_hz,
                    input bits_per_sample, input data_length, input sample_frames,
                    input duration_ms, output ready);
endinterface
`default_nettype wire

@@ src/wavp_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wavp_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [wavp_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  wire [wavp_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [wavp_pkg::DIVIDEND_W-1:0]  o_quotient
);
    import wavp_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_count, n_count;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVISOR_W-1:0]  r_divisor, n_divisor;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_count   = r_count;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        if (i_start) begin
            n_busy    = 1'b1;
            n_count   = '0;
            n_quo     = i_dividend;
            n_rem     = '0;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_quo   = {r_quo[DIVIDEND_W-2:0], w_ge};
            n_rem   = w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            n_count = r_count + 1'b1;
            if (r_count == CNT_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a running division");
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_count == CNT_LAST) |=> r_done)
        else $error("divider missed its final step");
`endif
endmodule
`default_nettype wire

@@ src/wavp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser controller
// Sequences header checks, the two divisions and the result load.
// ----------------------------------------------------------------------------
module wavp_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wavp_pkg::t_stat i_stat,
    output wavp_pkg::t_cmd  o_cmd
);
    import wavp_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN:        if (i_stat.hdr_done) n_state = S_CHECK;
            S_CHECK:      n_state = i_stat.pre_fail ? S_RUN : S_DIV_FRAMES;
            S_DIV_FRAMES: if (i_stat.div_done) n_state = S_PREP;
            S_PREP:       n_state = i_stat.rate_zero ? S_RUN : S_DIV_DUR;
            S_DIV_DUR:    if (i_stat.div_done) n_state = S_EMIT;
            S_EMIT:       n_state = S_RUN;
            default:      n_state = S_RUN;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_RUN:        o_cmd.in_ready = i_stat.out_free;
            S_CHECK: begin
                o_cmd.emit_fail    = i_stat.pre_fail;
                o_cmd.start_frames = !i_stat.pre_fail;
            end
            S_DIV_FRAMES: o_cmd.take_frames = i_stat.div_done;
            S_PREP: begin
                o_cmd.emit_final = i_stat.rate_zero;
                o_cmd.start_dur  = !i_stat.rate_zero;
            end
            S_DIV_DUR:    o_cmd.take_dur = i_stat.div_done;
            S_EMIT:       o_cmd.emit_final = 1'b1;
            default:      o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

@@ src/wavp_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser datapath
// Byte capture, tag check, frame and duration arithmetic, result register.
// ----------------------------------------------------------------------------
module wavp_dpath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wavp_pkg::t_cmd   i_cmd,
    output wavp_pkg::t_stat  o_stat,
    input  wire              i_in_valid,
    input  wire  [7:0]       i_data_byte,
    input  wire              i_last_byte,
    input  wire              i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_rate_hz,
    output logic [15:0]      o_bits_per_sample,
    output logic [31:0]      o_data_length,
    output logic [31:0]      o_sample_frames,
    output logic [41:0]      o_duration_ms
);
    import wavp_pkg::*;

    logic [OFF_W-1:0]      r_offset, n_offset;
    logic                  r_tags_ok, n_tags_ok;
    logic [15:0]           r_channels, n_channels;
    logic [31:0]           r_rate, n_rate;
    logic [15:0]           r_bits, n_bits;
    logic [31:0]           r_length, n_length;
    logic [31:0]           r_frames;
    logic                  r_lt;
    logic [DIVIDEND_W-1:0] r_dur;
    logic                  r_out_valid, n_out_valid;

    logic [2:0]            r_o_status;
    logic [15:0]           r_o_channels;
    logic [31:0]           r_o_rate;
    logic [15:0]           r_o_bits;
    logic [31:0]           r_o_length;
    logic [31:0]           r_o_frames;
    logic [DIVIDEND_W-1:0] r_o_dur;

    logic                  w_in_fire;
    logic                  w_emit_trunc;
    t_tag                  w_tag;
    t_status               w_pre;
    logic [16:0]           w_per_frame;
    logic                  w_div_start;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic [DIVISOR_W-1:0]  w_divisor;
    logic                  w_div_done;
    logic [DIVIDEND_W-1:0] w_quotient;
    logic [DIVIDEND_W-1:0] w_frames_ms;
    logic [DIVIDEND_W-1:0] w_quo_ms;

    assign w_in_fire    = i_in_valid && i_cmd.in_ready;
    assign w_emit_trunc = w_in_fire && i_last_byte && (r_offset < OFF_LAST_HDR);
    assign w_tag        = tag_at(r_offset);

    always_comb begin
        n_offset   = r_offset;
        n_tags_ok  = r_tags_ok;
        n_channels = r_channels;
        n_rate     = r_rate;
        n_bits     = r_bits;
        n_length   = r_length;
        if (w_in_fire) begin
            if (r_offset >= OFF_DONE) begin
                if (i_last_byte) n_offset = '0;
            end else begin
                if (r_offset == '0) begin
                    n_tags_ok  = 1'b1;
                    n_channels = '0;
                    n_rate     = '0;
                    n_bits     = '0;
                    n_length   = '0;
                end
                if (w_tag.checked && i_data_byte != w_tag.value) n_tags_ok = 1'b0;
                case (r_offset)
                    6'd22:   n_channels[7:0]  = i_data_byte;
                    6'd23:   n_channels[15:8] = i_data_byte;
                    6'd24:   n_rate[7:0]      = i_data_byte;
                    6'd25:   n_rate[15:8]     = i_data_byte;
                    6'd26:   n_rate[23:16]    = i_data_byte;
                    6'd27:   n_rate[31:24]    = i_data_byte;
                    6'd34:   n_bits[7:0]      = i_data_byte;
                    6'd35:   n_bits[15:8]     = i_data_byte;
                    6'd40:   n_length[7:0]    = i_data_byte;
                    6'd41:   n_length[15:8]   = i_data_byte;
                    6'd42:   n_length[23:16]  = i_data_byte;
                    6'd43:   n_length[31:24]  = i_data_byte;
                    default: n_channels = n_channels;
                endcase
                if (r_offset == OFF_LAST_HDR) begin
                    n_offset = i_last_byte ? '0 : OFF_DONE;
                end else if (i_last_byte) begin
                    n_offset = '0;
                end else begin
                    n_offset = r_offset + 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (!r_tags_ok) begin
            w_pre = ST_NOT_WAV;
        end else if (r_bits != 16'd8 && r_bits != 16'd16) begin
            w_pre = ST_BAD_SIZE;
        end else if (r_channels == '0) begin
            w_pre = ST_ZERO_CH;
        end else begin
            w_pre = ST_OK;
        end
    end

    assign w_per_frame = r_bits[4] ? {r_channels, 1'b0} : {1'b0, r_channels};
    assign w_frames_ms = DIVIDEND_W'(r_frames) * DIVIDEND_W'(MS_SCALE);
    assign w_quo_ms    = DIVIDEND_W'(w_quotient[31:0]) * DIVIDEND_W'(MS_SCALE);

    assign w_div_start = i_cmd.start_frames || i_cmd.start_dur;
    always_comb begin
        if (i_cmd.start_frames) begin
            w_dividend = DIVIDEND_W'(r_length);
            w_divisor  = DIVISOR_W'(w_per_frame);
        end else begin
            w_dividend = (r_frames < r_rate) ? w_frames_ms : DIVIDEND_W'(r_frames);
            w_divisor  = r_rate;
        end
    end

    wavp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (w_emit_trunc || i_cmd.emit_fail || i_cmd.emit_final) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_tags_ok   <= 1'b1;
            r_channels  <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_offset    <= n_offset;
            r_tags_ok   <= n_tags_ok;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_length    <= n_length;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_frames) r_frames <= w_quotient[31:0];
        if (i_cmd.start_dur)   r_lt     <= r_frames < r_rate;
        if (i_cmd.take_dur)    r_dur    <= r_lt ? w_quotient : w_quo_ms;
        if (w_emit_trunc) begin
            r_o_status   <= ST_TRUNC;
            r_o_channels <= '0;
            r_o_rate     <= '0;
            r_o_bits     <= '0;
            r_o_length   <= '0;
            r_o_frames   <= '0;
            r_o_dur      <= '0;
        end else if (i_cmd.emit_fail || i_cmd.emit_final) begin
            r_o_channels <= r_channels;
            r_o_rate     <= r_rate;
            r_o_bits     <= r_bits;
            r_o_length   <= r_length;
            if (i_cmd.emit_fail) begin
                r_o_status <= w_pre;
                r_o_frames <= '0;
                r_o_dur    <= '0;
            end else if (r_rate == '0) begin
                r_o_status <= ST_ZERO_RATE;
                r_o_frames <= r_frames;
                r_o_dur    <= '0;
            end else begin
                r_o_status <= ST_OK;
                r_o_frames <= r_frames;
                r_o_dur    <= r_dur;
            end
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.hdr_done  = w_in_fire && (r_offset == OFF_LAST_HDR);
    assign o_stat.pre_fail  = w_pre != ST_OK;
    assign o_stat.rate_zero = r_rate == '0;
    assign o_stat.div_done  = w_div_done;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_channel_count   = r_o_channels;
    assign o_rate_hz         = r_o_rate;
    assign o_bits_per_sample = r_o_bits;
    assign o_data_length     = r_o_length;
    assign o_sample_frames   = r_o_frames;
    assign o_duration_ms     = r_o_dur;

`ifndef ASSERT_OFF
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= OFF_DONE)
        else $error("byte offset beyond header end");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_fail || i_cmd.emit_final) |-> !r_out_valid)
        else $error("result load over a pending result");
    a_frames_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_frames |-> (r_channels != '0 && (r_bits == 16'd8 || r_bits == 16'd16)))
        else $error("frame division started with a zero divisor");
`endif
endmodule
`default_nettype wire

@@ src/wav_header_parser_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser
// Parses the 44-byte RIFF/PCM header of a byte stream and returns one result
// with the header fields, sample frame count and duration in milliseconds.
//
//   Channel  Dir  Item
//   i_in     in   data_byte[7:0], last_byte
//   o_out    out  status[2:0], channel_count, rate_hz, bits_per_sample,
//                 data_length, sample_frames, duration_ms[41:0]
//
// Header bytes and trailing bytes are taken one per cycle while input is not stalled.
// After byte 43 of a valid header, input stalls for two 42-step divisions
// (frames, then duration) on one shared radix-2 divider and the control
// states around them. A rejected header stalls input for the check state only,
// a zero rate through the check state, the frame division and the prep state.
// Input also stalls while a result sits unread in the output register.
// Reset is synchronous, active low, and returns the parser to offset zero.
// ----------------------------------------------------------------------------
module wav_header_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wavp_in_if.sink     i_in,
    wavp_out_if.source  o_out
);
    import wavp_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    wavp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    wavp_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_in_valid        (i_in.valid),
        .i_data_byte       (i_in.data_byte),
        .i_last_byte       (i_in.last_byte),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_channel_count   (o_out.channel_count),
        .o_rate_hz         (o_out.rate_hz),
        .o_bits_per_sample (o_out.bits_per_sample),
        .o_data_length     (o_out.data_length),
        .o_sample_frames   (o_out.sample_frames),
        .o_duration_ms     (o_out.duration_ms)
    );

    assign i_in.ready = w_cmd.in_ready;
endmodule
`default_nettype wire

@@ tb/wav_header_parser_top_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams whole and truncated WAV files into the parser byte by byte, and
// predicts each header result from a behavioral copy of the parser that
// tracks offset, tag matching and the captured little-endian fields. Results
// are compared field by field in arrival order. Directed files cover the
// field extremes, every status and the trailing-byte path. Random files,
// mostly well formed with random content, follow. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module wav_header_parser_top_test;
    import wavp_pkg::*;

    localparam logic [127:0] RIFF_TAGS   = {"RIFF", 32'h0, "WAVEfmt "};
    localparam int           FILE_TARGET = 1150;

    typedef struct packed {
        t_status     status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] bits_per_sample;
        logic [31:0] data_length;
        logic [31:0] sample_frames;
        logic [41:0] duration_ms;
    } t_hdr_result;

    logic i_clk;
    logic i_rst_n;

    wavp_in_if  in_ch ();
    wavp_out_if out_ch ();

    wav_header_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_hdr_result header_q[$];
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    bit          tx_gaps_on     = 1'b0;
    bit          rx_stalls_on   = 1'b0;
    logic [7:0]  hdr_buf [HDR_BYTES];

    int unsigned parse_pos;
    bit          tags_ok;
    logic [15:0] ch_acc;
    logic [31:0] rate_acc;
    logic [15:0] bits_acc;
    logic [31:0] len_acc;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("wav_header_parser_top_test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic t_hdr_result header_outcome();
        t_hdr_result     r;
        longint unsigned per_frame;
        longint unsigned frames;
        longint unsigned dur;
        r         = '0;
        frames    = 0;
        dur       = 0;
        r.status  = ST_OK;
        if (!tags_ok) begin
            r.status = ST_NOT_WAV;
        end else if (bits_acc != 16'd8 && bits_acc != 16'd16) begin
            r.status = ST_BAD_SIZE;
        end else if (ch_acc == 16'd0) begin
            r.status = ST_ZERO_CH;
        end else begin
            per_frame = 64'(ch_acc) * 64'(bits_acc >> 3);
            frames    = 64'(len_acc) / per_frame;
            if (rate_acc == 32'd0)
                r.status = ST_ZERO_RATE;
            else if (frames < 64'(rate_acc))
                dur = frames * 64'd1000 / 64'(rate_acc);
            else
                dur = (frames / 64'(rate_acc)) * 64'd1000;
        end
        r.channel_count   = ch_acc;
        r.rate_hz         = rate_acc;
        r.bits_per_sample = bits_acc;
        r.data_length     = len_acc;
        r.sample_frames   = frames[31:0];
        r.duration_ms     = dur[41:0];
        return r;
    endfunction

    task automatic predict_byte(input logic [7:0] d, input logic l);
        t_hdr_result r;
        if (parse_pos >= HDR_BYTES) begin
            if (l) parse_pos = 0;
            return;
        end
        if (parse_pos == 0) begin
            tags_ok  = 1'b1;
            ch_acc   = '0;
            rate_acc = '0;
            bits_acc = '0;
            len_acc  = '0;
        end
        if ((parse_pos < 4 || (parse_pos >= 8 && parse_pos < 16)) &&
            d != RIFF_TAGS[127 - 8*parse_pos -: 8])
            tags_ok = 1'b0;
        if (parse_pos >= 22 && parse_pos < 24)
            ch_acc[8*(parse_pos-22) +: 8] = d;
        else if (parse_pos >= 24 && parse_pos < 28)
            rate_acc[8*(parse_pos-24) +: 8] = d;
        else if (parse_pos >= 34 && parse_pos < 36)
            bits_acc[8*(parse_pos-34) +: 8] = d;
        else if (parse_pos >= 40 && parse_pos < 44)
            len_acc[8*(parse_pos-40) +: 8] = d;

        if (parse_pos == HDR_BYTES - 1) begin
            header_q.push_back(header_outcome());
            parse_pos = l ? 0 : HDR_BYTES;
        end else if (l) begin
            r        = '0;
            r.status = ST_TRUNC;
            header_q.push_back(r);
            parse_pos = 0;
        end else begin
            parse_pos++;
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = d;
        in_ch.last_byte = l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_byte(d, l);
        @(negedge i_clk);
    endtask

    task automatic fill_header(input logic [15:0] ch, input logic [31:0] rate,
                               input logic [15:0] bits, input logic [31:0] len);
        for (int i = 0; i < HDR_BYTES; i++) hdr_buf[i] = 8'($urandom);
        for (int i = 0; i < 16; i++)
            if (i < 4 || i >= 8) hdr_buf[i] = RIFF_TAGS[127 - 8*i -: 8];
        for (int i = 0; i < 2; i++) hdr_buf[22+i] = ch[8*i +: 8];
        for (int i = 0; i < 4; i++) hdr_buf[24+i] = rate[8*i +: 8];
        for (int i = 0; i < 2; i++) hdr_buf[34+i] = bits[8*i +: 8];
        for (int i = 0; i < 4; i++) hdr_buf[40+i] = len[8*i +: 8];
    endtask

    // Send hdr_len header bytes; a full header is followed by trail extra bytes.
    task automatic send_stream(input int hdr_len, input int trail);
        for (int i = 0; i < hdr_len; i++) begin
            bytes_sent++;
            send_byte(hdr_buf[i], (i == hdr_len - 1) && (hdr_len < HDR_BYTES || trail == 0));
        end
        if (hdr_len == HDR_BYTES)
            for (int i = 0; i < trail; i++) begin
                bytes_sent++;
                send_byte(8'($urandom), i == trail - 1);
            end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : check_results
        t_hdr_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (header_q.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                want = header_q.pop_front();
                check_field("status", 64'(out_ch.status), 64'(want.status));
                check_field("channel_count", 64'(out_ch.channel_count),
                            64'(want.channel_count));
                check_field("rate_hz", 64'(out_ch.rate_hz), 64'(want.rate_hz));
                check_field("bits_per_sample", 64'(out_ch.bits_per_sample),
                            64'(want.bits_per_sample));
                check_field("data_length", 64'(out_ch.data_length), 64'(want.data_length));
                check_field("sample_frames", 64'(out_ch.sample_frames),
                            64'(want.sample_frames));
                check_field("duration_ms", 64'(out_ch.duration_ms), 64'(want.duration_ms));
            end
        end
    end

    initial begin : drive_ready
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                if (rx_stalls_on) stall_left = pick_gap();
            end
        end
    end

    task automatic test_truncation();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hdr_buf[0] = "R";
        send_stream(1, 0);
        fill_header(16'd2, 32'd44100, 16'd16, 32'd176400);
        send_stream(43, 0);
        fill_header(16'd1, 32'd8000, 16'd8, 32'd8000);
        hdr_buf[5] = 8'h00;
        send_stream(6, 0);
        fill_header(16'd2, 32'd48000, 16'd16, 32'd96000);
        send_stream(HDR_BYTES, 0);
    endtask

    task automatic test_field_extremes();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b0;
        fill_header(16'hFFFF, 32'hFFFF_FFFF, 16'd16, 32'hFFFF_FFFF);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd1, 32'd1, 16'd8, 32'hFFFF_FFFF);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd2, 32'd48000, 16'd16, 32'd96000);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd1, 32'd44100, 16'd8, 32'd0);
        send_stream(HDR_BYTES, 0);
        fill_header(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_stream(HDR_BYTES, 0);
    endtask

    task automatic test_status_codes();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        fill_header(16'd2, 32'd44100, 16'd16, 32'd1000);
        hdr_buf[15] = 8'h00;
        send_stream(HDR_BYTES, 0);
        fill_header(16'd2, 32'd44100, 16'd0, 32'd1000);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd2, 32'd44100, 16'd24, 32'd1000);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd0, 32'd44100, 16'd16, 32'd1000);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd2, 32'd0, 16'd16, 32'd1000);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd0, 32'd0, 16'd8, 32'd1000);
        send_stream(HDR_BYTES, 0);
        fill_header(16'd0, 32'd0, 16'd7, 32'd1000);
        hdr_buf[0] = 8'hFF;
        send_stream(HDR_BYTES, 0);
    endtask

    task automatic test_trailing_bytes();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        fill_header(16'd1, 32'd22050, 16'd8, 32'd11025);
        send_stream(HDR_BYTES, 10);
        fill_header(16'd2, 32'd16000, 16'd16, 32'd64000);
        send_stream(HDR_BYTES, 1);
    endtask

    task automatic test_random_files();
        int          kind;
        int          hdr_len;
        int          trail;
        int          idx;
        logic [15:0] ch;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] len;
        while (bytes_sent < FILE_TARGET) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            ch   = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 8)) : 16'($urandom);
            if (ch == 16'd0) ch = 16'd1;
            rate = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(1, 200000)) : $urandom;
            if (rate == 32'd0) rate = 32'd1;
            bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
            len  = $urandom_range(0, 1) ? 32'($urandom_range(0, 400000)) : $urandom;
            hdr_len = HDR_BYTES;
            if (kind < 90) fill_header(ch, rate, bits, len);
            if (kind >= 60 && kind < 70) begin
                idx = $urandom_range(0, 11);
                idx = (idx < 4) ? idx : idx + 4;
                hdr_buf[idx] = hdr_buf[idx] ^ 8'($urandom_range(1, 255));
            end else if (kind >= 70 && kind < 78) begin
                for (int i = 0; i < 2; i++) hdr_buf[34+i] = 8'($urandom);
            end else if (kind >= 78 && kind < 84) begin
                hdr_buf[22] = 8'h00;
                hdr_buf[23] = 8'h00;
            end else if (kind >= 84 && kind < 90) begin
                for (int i = 0; i < 4; i++) hdr_buf[24+i] = 8'h00;
            end else if (kind >= 90 && kind < 96) begin
                fill_header(ch, rate, bits, len);
                hdr_len = $urandom_range(1, HDR_BYTES - 1);
            end else if (kind >= 96) begin
                for (int i = 0; i < HDR_BYTES; i++) hdr_buf[i] = 8'($urandom);
            end
            idx   = $urandom_range(0, 9);
            trail = (idx < 4) ? 0 : (idx < 9) ? $urandom_range(1, 6) : $urandom_range(20, 60);
            send_stream(hdr_len, trail);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.last_byte = 1'b0;
        parse_pos       = 0;
        tags_ok         = 1'b1;
        ch_acc          = '0;
        rate_acc        = '0;
        bits_acc        = '0;
        len_acc         = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_truncation();
        test_field_extremes();
        test_status_codes();
        test_trailing_bytes();
        test_random_files();

        in_ch.valid = 1'b0;
        while (header_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("wav_header_parser_top_test passed");
        else
            $display("wav_header_parser_top_test failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/wavp_pkg.sv
src/wavp_if.sv
src/wavp_div.sv
src/wavp_ctrl.sv
src/wavp_dpath.sv
src/wav_header_parser_top.sv
tb/wav_header_parser_top_test.sv
